@@ hdl/s2i64_pkg.sv @@
// Shared types, character codes and digit decode for the string to int64 parser.
// Used by s2i64_fsm and string_to_int64_parser; no dependencies.

package s2i64_pkg;

    localparam int unsigned COUNT_W = 8;
    localparam int unsigned BASE_W  = 6;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [BASE_W-1:0]  base_t;
    typedef logic [7:0]         char_t;

    localparam count_t COUNT_MAX = 8'd255;

    localparam base_t BASE_AUTO  = 6'd0;
    localparam base_t BASE_MIN   = 6'd2;
    localparam base_t BASE_OCTAL = 6'd8;
    localparam base_t BASE_DEC   = 6'd10;
    localparam base_t BASE_HEX   = 6'd16;
    localparam base_t BASE_MAX   = 6'd36;

    localparam char_t CH_TAB   = 8'h09;
    localparam char_t CH_CR    = 8'h0D;
    localparam char_t CH_SPACE = 8'h20;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_NINE  = 8'h39;
    localparam char_t CH_UP_A  = 8'h41;
    localparam char_t CH_UP_X  = 8'h58;
    localparam char_t CH_UP_Z  = 8'h5A;
    localparam char_t CH_LO_A  = 8'h61;
    localparam char_t CH_LO_X  = 8'h78;
    localparam char_t CH_LO_Z  = 8'h7A;

    localparam char_t DIGIT_NONE = 8'hFF;

    // Result of one completed string
    typedef struct packed {
        logic signed [63:0] value;
        count_t             count;
        logic               error;
    } s2i64_result_t;

    // Digit value 0..35 of a character, DIGIT_NONE for anything else
    function automatic char_t digit_value(input char_t c);
        char_t d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = c - CH_ZERO;
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d = c - CH_UP_A + 8'd10;
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d = c - CH_LO_A + 8'd10;
        end
        return d;
    endfunction

endpackage

@@ hdl/string_to_int64_parser.sv @@
// String to signed 64-bit integer parser, one character per request.
// The result of a final character is registered once the result slot is free.
// Throughput: one character per cycle, save a final character facing a full slot;
// the result register lets the next string go on while a result awaits out_ready.
// Reset (rst_n, async, active low): parse state cleared, number_base = 0 (auto).
// Depends on s2i64_pkg and s2i64_fsm.

module string_to_int64_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  s2i64_pkg::base_t          number_base,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  s2i64_pkg::char_t          char_code,
    input  logic                      last_char,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [63:0]        value,
    output s2i64_pkg::count_t         consumed_count,
    output logic                      base_error
);
    import s2i64_pkg::*;

    base_t         base_cfg_reg;
    logic          in_valid_reg;
    char_t         char_reg;
    logic          last_reg;
    logic          out_valid_reg;
    s2i64_result_t result_reg;
    s2i64_result_t result;
    logic          out_free;
    logic          step;

    assign out_free = !out_valid_reg || out_ready;
    // a final character needs a free result slot, others advance at once
    assign step     = in_valid_reg && (!last_reg || out_free);
    assign in_ready = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    s2i64_fsm u_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .char_code   (char_reg),
        .last_char   (last_reg),
        .number_base (base_cfg_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_cfg_reg  <= BASE_AUTO;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_cfg_reg <= number_base;
            end
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_code;
            last_reg <= last_char;
        end
        if (step && last_reg)
        begin
            result_reg <= result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign value          = result_reg.value;
    assign consumed_count = result_reg.count;
    assign base_error     = result_reg.error;

`ifndef SYNTHESIS
    a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && base_error |-> value == '0 && consumed_count == '0)
        else $error("base error result carries nonzero value or count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !(step && last_reg) |=> !out_valid_reg)
        else $error("result appeared without a final character");

    a_pending_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(char_reg) && $stable(last_reg))
        else $error("pending character dropped or changed");
`endif

endmodule

@@ hdl/s2i64_fsm.sv @@
// Parse state machine: whitespace, sign, prefix and digit accumulation,
// one character per strobe. Depends on s2i64_pkg.

module s2i64_fsm (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  s2i64_pkg::char_t        char_code,
    input  logic                    last_char,
    input  s2i64_pkg::base_t        number_base,
    output s2i64_pkg::s2i64_result_t result
);
    import s2i64_pkg::*;

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_SIGN,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        neg_reg, neg_next;
    logic [63:0] acc_reg, acc_next;
    base_t       base_reg, base_next;
    count_t      count_reg, count_next;

    char_t       digit;
    base_t       digit_base;
    base_t       auto_base;
    base_t       end_base;
    logic        take_digit;
    logic [1:0]  inc;
    logic [8:0]  count_sum;
    logic [8:0]  end_sum;
    count_t      end_count;
    logic        end_error;
    logic [63:0] product;

    assign digit     = digit_value(char_code);
    assign auto_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
    assign product   = acc_reg * 64'(digit_base);

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        base_next  = base_reg;
        take_digit = 1'b0;
        digit_base = base_reg;
        inc        = 2'd0;

        case (phase_reg)
            PH_SKIP, PH_SIGN:
            begin
                if (phase_reg == PH_SKIP && (char_code == CH_SPACE ||
                    (char_code >= CH_TAB && char_code <= CH_CR)))
                begin
                    inc = 2'd1;
                end
                else if (phase_reg == PH_SKIP &&
                         (char_code == CH_MINUS || char_code == CH_PLUS))
                begin
                    neg_next   = (char_code == CH_MINUS);
                    inc        = 2'd1;
                    phase_next = PH_SIGN;
                end
                else if (char_code == CH_ZERO &&
                         (number_base == BASE_AUTO || number_base == BASE_HEX))
                begin
                    // hold the zero until the next character decides the prefix
                    base_next  = number_base;
                    phase_next = PH_ZERO;
                end
                else
                begin
                    base_next  = auto_base;
                    phase_next = PH_DIGITS;
                    take_digit = 1'b1;
                    digit_base = auto_base;
                end
            end
            PH_ZERO:
            begin
                phase_next = PH_DIGITS;
                if (char_code == CH_LO_X || char_code == CH_UP_X)
                begin
                    base_next = BASE_HEX;
                    inc       = 2'd2;
                end
                else
                begin
                    base_next  = (base_reg == BASE_AUTO) ? BASE_OCTAL : base_reg;
                    inc        = 2'd1;
                    take_digit = 1'b1;
                    digit_base = (base_reg == BASE_AUTO) ? BASE_OCTAL : base_reg;
                end
            end
            PH_DIGITS:
            begin
                take_digit = 1'b1;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (take_digit)
        begin
            if (digit < {2'b00, digit_base})
            begin
                acc_next = product + 64'(digit);
                inc      = inc + 2'd1;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        count_sum  = {1'b0, count_reg} + 9'(inc);
        count_next = (count_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : count_sum[7:0];
    end

    // Finish: a lone pending zero is consumed, otherwise check the resolved base
    always_comb
    begin
        end_sum  = {1'b0, count_next} + 9'd1;
        end_base = base_next;
        if (phase_next == PH_SKIP || phase_next == PH_SIGN)
        begin
            end_base = auto_base;
        end

        if (phase_next == PH_ZERO)
        begin
            end_error = 1'b0;
            end_count = (end_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : end_sum[7:0];
        end
        else
        begin
            end_error = (end_base < BASE_MIN) || (end_base > BASE_MAX);
            end_count = count_next;
        end

        result.error = end_error;
        result.count = end_error ? '0 : end_count;
        result.value = end_error ? '0 : (neg_next ? -acc_next : acc_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            base_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            if (last_char)
            begin
                phase_reg <= PH_SKIP;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
                base_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                base_reg  <= base_next;
                count_reg <= count_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_char |=> phase_reg == PH_SKIP && acc_reg == '0 && count_reg == '0)
        else $error("parse state not cleared after final character");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE && step && !last_char |=> phase_reg == PH_DONE &&
        $stable(acc_reg) && $stable(count_reg))
        else $error("state changed after digits ended");

    a_zero_base: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ZERO |-> base_reg == BASE_AUTO || base_reg == BASE_HEX)
        else $error("pending zero held with a base other than auto or hex");
`endif

endmodule
